// ----- design/dsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dsfr_pkg
// Shared types and constants for the DLE/STX/ETX frame receiver.
// ----------------------------------------------------------------------------
package dsfr_pkg;

  // framing bytes
  localparam logic [7:0] DLE_BYTE        = 8'h10;
  localparam logic [7:0] STX_BYTE        = 8'h02;
  localparam logic [7:0] ETX_BYTE        = 8'h03;
  localparam logic [7:0] LENGTH_AT_RESET = 8'd44;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  typedef enum logic [2:0] {
    ST_GOOD     = 3'd0,
    ST_BAD_STX  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_CHK  = 3'd3,
    ST_BAD_EDLE = 3'd4,
    ST_BAD_ETX  = 3'd5
  } status_t;

  // parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_STX  = 7'b0000010,
    PH_LEN  = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CHK  = 7'b0010000,
    PH_EDLE = 7'b0100000,
    PH_ETX  = 7'b1000000
  } phase_t;

  // one result word from the parser
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    status_t    status;
  } result_t;

endpackage

// ----- design/dsfr_parser.sv -----
// ----------------------------------------------------------------------------
// dsfr_parser
// Frame state machine: consumes one byte per step, keeps phase, remaining
// count, payload position and running XOR, and forms the result word.
// ----------------------------------------------------------------------------
module dsfr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           expected_length,
  output dsfr_pkg::result_t    result
);

  dsfr_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] position, position_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] left_dec;

  assign left_dec = bytes_left - 8'd1;

  // next state and result for the current byte
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    position_next    = position;
    running_xor_next = running_xor;
    result           = '0;
    result.status    = dsfr_pkg::ST_GOOD;
    unique case (phase)
      dsfr_pkg::PH_STX: begin
        if (rx_byte == dsfr_pkg::STX_BYTE) begin
          phase_next = dsfr_pkg::PH_LEN;
        end else begin
          result.valid  = 1'b1;
          result.kind   = dsfr_pkg::KIND_STATUS;
          result.status = dsfr_pkg::ST_BAD_STX;
          phase_next    = dsfr_pkg::PH_HUNT;
        end
      end
      dsfr_pkg::PH_LEN: begin
        if (rx_byte != expected_length) begin
          result.valid  = 1'b1;
          result.kind   = dsfr_pkg::KIND_STATUS;
          result.status = dsfr_pkg::ST_BAD_LEN;
          phase_next    = dsfr_pkg::PH_HUNT;
        end else begin
          bytes_left_next  = rx_byte;
          position_next    = '0;
          running_xor_next = '0;
          phase_next = (rx_byte == 8'd0) ? dsfr_pkg::PH_CHK : dsfr_pkg::PH_DATA;
        end
      end
      dsfr_pkg::PH_DATA: begin
        result.valid     = 1'b1;
        result.kind      = dsfr_pkg::KIND_PAYLOAD;
        result.data      = rx_byte;
        result.index     = position;
        running_xor_next = running_xor ^ rx_byte;
        position_next    = position + 8'd1;
        bytes_left_next  = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = dsfr_pkg::PH_CHK;
        end
      end
      dsfr_pkg::PH_CHK: begin
        if (rx_byte == running_xor) begin
          phase_next = dsfr_pkg::PH_EDLE;
        end else begin
          result.valid  = 1'b1;
          result.kind   = dsfr_pkg::KIND_STATUS;
          result.status = dsfr_pkg::ST_BAD_CHK;
          phase_next    = dsfr_pkg::PH_HUNT;
        end
      end
      dsfr_pkg::PH_EDLE: begin
        if (rx_byte == dsfr_pkg::DLE_BYTE) begin
          phase_next = dsfr_pkg::PH_ETX;
        end else begin
          result.valid  = 1'b1;
          result.kind   = dsfr_pkg::KIND_STATUS;
          result.status = dsfr_pkg::ST_BAD_EDLE;
          phase_next    = dsfr_pkg::PH_HUNT;
        end
      end
      dsfr_pkg::PH_ETX: begin
        result.valid  = 1'b1;
        result.kind   = dsfr_pkg::KIND_STATUS;
        result.status = (rx_byte == dsfr_pkg::ETX_BYTE) ? dsfr_pkg::ST_GOOD
                                                         : dsfr_pkg::ST_BAD_ETX;
        phase_next    = dsfr_pkg::PH_HUNT;
      end
      default: begin
        // hunting: only an opening DLE moves on
        phase_next = (rx_byte == dsfr_pkg::DLE_BYTE) ? dsfr_pkg::PH_STX
                                                      : dsfr_pkg::PH_HUNT;
      end
    endcase
  end

  // state registers advance only on a processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dsfr_pkg::PH_HUNT;
      bytes_left  <= '0;
      position    <= '0;
      running_xor <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      position    <= position_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

// ----- design/dle_stx_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// dle_stx_frame_receiver_top
// Receives a byte stream, recognizes DLE STX LEN payload CHK DLE ETX frames,
// passes out payload bytes with their index and one status per frame.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  rx       | rx_valid / rx_ready          | rx_byte
//  result   | result_valid / result_ready  | result_kind, payload_byte,
//           |                              | byte_index, frame_status
//  cfg      | cfg_write_en (no wait)       | cfg_write_data (expected_length)
//
// One byte per cycle sustained while result_ready is held high. A byte is
// held in the input register, then the parser step writes the output register.
// rst is synchronous: parser hunts for DLE, both registers empty, length 44.
// A stalled result holds the output register; the input register holds its
// byte behind it, and rx_ready drops only when both are full.
// ----------------------------------------------------------------------------
module dle_stx_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       result_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] byte_index,
  output logic [2:0] frame_status
);

  logic [7:0]        expected_length;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_free;
  logic              step;
  dsfr_pkg::result_t result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= dsfr_pkg::LENGTH_AT_RESET;
    end else if (cfg_write_en) begin
      expected_length <= cfg_write_data;
    end
  end

  // pipeline control
  assign out_free = !result_valid || result_ready;
  assign step     = in_valid && out_free;
  assign rx_ready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_ready) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  dsfr_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .rx_byte         (in_byte),
    .expected_length (expected_length),
    .result          (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      result_kind  <= result.kind;
      payload_byte <= result.data;
      byte_index   <= result.index;
      frame_status <= result.status;
    end
  end

  // checks
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == dsfr_pkg::KIND_STATUS) |->
      (payload_byte == 8'd0 && byte_index == 8'd0 && frame_status <= 3'd5))
    else $error("status result carries payload fields");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == dsfr_pkg::KIND_PAYLOAD) |->
      (frame_status == 3'd0))
    else $error("payload result carries a status code");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && result_valid && !result_ready) |=>
      (in_valid && $stable(in_byte)))
    else $error("input byte lost under output stall");

endmodule
